// File: hdl/tcq_pkg.sv
// ----------------------------------------------------------------------------
// tcq_pkg
// Shared constants, codes and control types of the ticketed circular queue.
// ----------------------------------------------------------------------------
package tcq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int TAG_W      = 64;
  localparam int TICKET_W   = 32;
  localparam int POS_W      = 5;
  localparam int STATUS_W   = 2;
  localparam int KIND_W     = 2;
  localparam int CAP_W      = 5;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [CAP_W-1:0]    CAP_RESET    = 5'd10;
  localparam logic [TICKET_W-1:0] TICKET_RESET = 32'd1;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIST = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // register word index
  localparam logic [CFG_AW-3:0] REG_CAPACITY = '0;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic enq_ok;    // write the entry and report its ticket
    logic ld_full;   // report a refused enqueue
    logic ld_empty;  // report an empty queue
    logic rd_start;  // read the oldest entry
    logic ld_deq;    // report the read entry and remove it
    logic ld_list;   // report the read entry and fetch the next one
  } tcq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              empty;
    logic              slot_free;
    logic              list_last;
  } tcq_stat_t;

endpackage

// File: hdl/tcq_ifs.sv
// ----------------------------------------------------------------------------
// tcq_ifs
// Valid/ready channels of the ticketed circular queue.
// ----------------------------------------------------------------------------
interface tcq_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcq_pkg::KIND_W-1:0]   kind;
  logic [tcq_pkg::TAG_W-1:0]    client_tag;

  modport source (output valid, output kind, output client_tag, input ready);
  modport sink   (input valid, input kind, input client_tag, output ready);
endinterface

interface tcq_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcq_pkg::STATUS_W-1:0]  status;
  logic [tcq_pkg::POS_W-1:0]     position;
  logic [tcq_pkg::TAG_W-1:0]     entry_tag;
  logic [tcq_pkg::TICKET_W-1:0]  ticket;
  logic                          last;

  modport source (output valid, output status, output position, output entry_tag,
                  output ticket, output last, input ready);
  modport sink   (input valid, input status, input position, input entry_tag,
                  input ticket, input last, output ready);
endinterface

// File: hdl/tcq_ram.sv
// ----------------------------------------------------------------------------
// tcq_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

// File: hdl/tcq_ctrl.sv
// ----------------------------------------------------------------------------
// tcq_ctrl
// Sequencer of the queue: takes one item, issues datapath commands.
// ----------------------------------------------------------------------------
module tcq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcq_pkg::tcq_stat_t stat,
  output tcq_pkg::tcq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.kind)
          tcq_pkg::KIND_ENQ: begin
            if (stat.slot_free) begin
              cmd.ld_full = stat.full;
              cmd.enq_ok  = !stat.full;
              state_nxt   = S_IDLE;
            end
          end
          tcq_pkg::KIND_DEQ, tcq_pkg::KIND_LIST: begin
            if (stat.slot_free) begin
              if (stat.empty) begin
                cmd.ld_empty = 1'b1;
                state_nxt    = S_IDLE;
              end else begin
                cmd.rd_start = 1'b1;
                state_nxt    = S_READ;
              end
            end
          end
          default: begin
            // unused operation: drop it
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        if (stat.slot_free) begin
          if (stat.kind == tcq_pkg::KIND_DEQ) begin
            cmd.ld_deq = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.ld_list = 1'b1;
            if (stat.list_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/tcq_dp.sv
// ----------------------------------------------------------------------------
// tcq_dp
// Queue datapath: pointers, ticket counter, entry RAM and result register.
// ----------------------------------------------------------------------------
module tcq_dp #(
  parameter int DEPTH = tcq_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tcq_pkg::tcq_cmd_t              cmd,
  output tcq_pkg::tcq_stat_t             stat,
  input  logic [tcq_pkg::KIND_W-1:0]     in_kind,
  input  logic [tcq_pkg::TAG_W-1:0]      in_tag,
  input  logic                           cap_we,
  input  logic [tcq_pkg::CAP_W-1:0]      cap_wdata,
  output logic [tcq_pkg::CAP_W-1:0]      cap_q,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcq_pkg::STATUS_W-1:0]   out_status,
  output logic [tcq_pkg::POS_W-1:0]      out_position,
  output logic [tcq_pkg::TAG_W-1:0]      out_entry_tag,
  output logic [tcq_pkg::TICKET_W-1:0]   out_ticket,
  output logic                           out_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = tcq_pkg::TAG_W + tcq_pkg::TICKET_W;

  logic [tcq_pkg::CAP_W-1:0]    cap_r;
  logic [IW-1:0]                head_r, tail_r, idx_r;
  logic [CW-1:0]                cnt_r, pos_r, eff_cap;
  logic [tcq_pkg::TICKET_W-1:0] tkt_r;
  logic [tcq_pkg::KIND_W-1:0]   kind_r;
  logic [tcq_pkg::TAG_W-1:0]    tag_r;

  logic                          ov_r;
  logic [tcq_pkg::STATUS_W-1:0]  o_status_r;
  logic [tcq_pkg::POS_W-1:0]     o_pos_r;
  logic [tcq_pkg::TAG_W-1:0]     o_tag_r;
  logic [tcq_pkg::TICKET_W-1:0]  o_tkt_r;
  logic                          o_last_r;

  logic          ram_rd_en;
  logic [IW-1:0] ram_rd_addr;
  logic [EW-1:0] ram_rd_data;
  logic          load;
  logic          list_last;

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] i,
                                        input logic [CW-1:0] cap);
    logic [CW-1:0] nx;
    nx  = CW'(i) + CW'(1);
    adv = (nx >= cap) ? '0 : IW'(nx);
  endfunction

  // saturate the capacity register into 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (32'(cap_r) > 32'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap_r);
    end
  end

  assign list_last = (pos_r == cnt_r);
  assign load      = cmd.enq_ok | cmd.ld_full | cmd.ld_empty | cmd.ld_deq | cmd.ld_list;

  assign stat.kind      = kind_r;
  assign stat.full      = (cnt_r >= eff_cap);
  assign stat.empty     = (cnt_r == '0);
  assign stat.slot_free = !ov_r || out_ready;
  assign stat.list_last = list_last;

  assign ram_rd_en   = cmd.rd_start | (cmd.ld_list & !list_last);
  assign ram_rd_addr = cmd.rd_start ? head_r : adv(idx_r, eff_cap);

  tcq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (cmd.enq_ok),
    .wr_addr   (tail_r),
    .wr_data   ({tag_r, tkt_r}),
    .rd_en     (ram_rd_en),
    .rd_addr   (ram_rd_addr),
    .rd_data_r (ram_rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= tcq_pkg::CAP_RESET;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      tkt_r  <= tcq_pkg::TICKET_RESET;
      ov_r   <= 1'b0;
    end else begin
      if (cap_we) begin
        // a new capacity empties the queue
        cap_r  <= cap_wdata;
        head_r <= '0;
        tail_r <= '0;
        cnt_r  <= '0;
      end else if (cmd.enq_ok) begin
        tail_r <= adv(tail_r, eff_cap);
        cnt_r  <= cnt_r + CW'(1);
        tkt_r  <= tkt_r + tcq_pkg::TICKET_W'(1);
      end else if (cmd.ld_deq) begin
        head_r <= adv(head_r, eff_cap);
        cnt_r  <= cnt_r - CW'(1);
      end
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // item and list walk
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      tag_r  <= in_tag;
    end
    if (cmd.rd_start) begin
      idx_r <= head_r;
      pos_r <= CW'(1);
    end else if (cmd.ld_list) begin
      idx_r <= adv(idx_r, eff_cap);
      pos_r <= pos_r + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      o_status_r <= tcq_pkg::ST_OK;
      o_pos_r    <= '0;
      o_tag_r    <= '0;
      o_tkt_r    <= '0;
      o_last_r   <= 1'b1;
      if (cmd.ld_full) begin
        o_status_r <= tcq_pkg::ST_FULL;
      end
      if (cmd.ld_empty) begin
        o_status_r <= tcq_pkg::ST_EMPTY;
      end
      if (cmd.enq_ok) begin
        o_tkt_r <= tkt_r;
      end
      if (cmd.ld_deq || cmd.ld_list) begin
        o_tag_r <= ram_rd_data[EW-1:tcq_pkg::TICKET_W];
        o_tkt_r <= ram_rd_data[tcq_pkg::TICKET_W-1:0];
      end
      if (cmd.ld_list) begin
        o_pos_r  <= tcq_pkg::POS_W'(pos_r);
        o_last_r <= list_last;
      end
    end
  end

  assign cap_q         = cap_r;
  assign out_valid     = ov_r;
  assign out_status    = o_status_r;
  assign out_position  = o_pos_r;
  assign out_entry_tag = o_tag_r;
  assign out_ticket    = o_tkt_r;
  assign out_last      = o_last_r;

endmodule

// File: hdl/ticketed_circular_queue_top.sv
// ----------------------------------------------------------------------------
// ticketed_circular_queue_top
// Circular service queue of client tags stamped with running tickets.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one operation per transfer: enqueue a client tag, dequeue
//   the oldest entry, or list every entry. out_ch returns the results; every
//   operation ends with a result that has last set, and a list gives one
//   result per queued entry, oldest first, with its one-based position.
//   Unused operation codes give no result.
//   The cfg_ port holds the capacity register at byte address 0; writing it
//   empties the queue but keeps the ticket counter. Write it only when idle.
// Sequence:
//   One item is in work at a time. Enqueue, a full enqueue and an empty
//   dequeue or list load their result from the exec state; a dequeue and
//   each list entry first pass the registered read port of the entry RAM,
//   which feeds the result register. in_ch is ready again the cycle after
//   the last result is loaded.
// Reset: rst_n (synchronous) empties the queue, sets the next ticket to 1
//   and the capacity to 10. RAM contents are not cleared.
// Stall: a held result waits in the output register; the next item can be
//   taken meanwhile and waits for that register to drain.
// ----------------------------------------------------------------------------
module ticketed_circular_queue_top #(
  parameter int DEPTH = tcq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tcq_in_if.sink                      in_ch,
  tcq_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tcq_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tcq_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tcq_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  tcq_pkg::tcq_cmd_t          cmd;
  tcq_pkg::tcq_stat_t         stat;
  logic                       cap_sel;
  logic                       cap_we;
  logic [tcq_pkg::CAP_W-1:0]  cap_q;

  assign cfg_pready = 1'b1;
  assign cap_sel    = (cfg_paddr[tcq_pkg::CFG_AW-1:2] == tcq_pkg::REG_CAPACITY);
  assign cap_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & cap_sel;
  assign cfg_prdata = cap_sel ? tcq_pkg::CFG_DW'(cap_q) : '0;

  tcq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (in_ch.kind),
    .in_tag        (in_ch.client_tag),
    .cap_we        (cap_we),
    .cap_wdata     (cfg_pwdata[tcq_pkg::CAP_W-1:0]),
    .cap_q         (cap_q),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_position  (out_ch.position),
    .out_entry_tag (out_ch.entry_tag),
    .out_ticket    (out_ch.ticket),
    .out_last      (out_ch.last)
  );

  // at most one result load per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.enq_ok, cmd.ld_full, cmd.ld_empty, cmd.ld_deq, cmd.ld_list}))
    else $error("several result loads in one cycle");

  // a result is loaded only into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.enq_ok || cmd.ld_full || cmd.ld_empty || cmd.ld_deq || cmd.ld_list)
      |-> stat.slot_free)
    else $error("result load over a held result");

  // one item at a time: input closes after a transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input still open after a transfer");

  // a refused enqueue never writes the RAM
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_ok |-> !stat.full)
    else $error("enqueue into a full queue");

endmodule

// File: tb/tb_ticketed_circular_queue_top.sv
// ----------------------------------------------------------------------------
// tb_ticketed_circular_queue_top
// Self-checking regression of the ticketed circular queue. It starts with
// directed checks of reset state, full and empty handling, unused codes and
// capacity clamping. Random traffic then runs across several capacities and
// idle/stall mixes. A local queue model predicts every result, and each
// result transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ticketed_circular_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = tcq_pkg::DEPTH_DEF;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [tcq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [tcq_pkg::CFG_AW-1:0] CAP_ADDR    = {tcq_pkg::REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic [tcq_pkg::STATUS_W-1:0] status;
    logic [tcq_pkg::POS_W-1:0]    position;
    logic [tcq_pkg::TAG_W-1:0]    entry_tag;
    logic [tcq_pkg::TICKET_W-1:0] ticket;
    logic                         last;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [tcq_pkg::CFG_AW-1:0] cfg_paddr;
  logic [tcq_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [tcq_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  tcq_in_if  in_if ();
  tcq_out_if out_if ();

  ticketed_circular_queue_top #(.DEPTH(DEPTH)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // queue model state
  logic [tcq_pkg::TAG_W-1:0]    model_tags    [DEPTH];
  logic [tcq_pkg::TICKET_W-1:0] model_tickets [DEPTH];
  int unsigned                  model_head;
  int unsigned                  model_tail;
  int unsigned                  model_count;
  logic [tcq_pkg::TICKET_W-1:0] model_next_ticket;
  logic [tcq_pkg::CAP_W-1:0]    model_capacity;

  queue_result_t pending_results[$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned ops_sent;
  int unsigned results_checked;
  int unsigned cap_writes;
  int unsigned errors;
  int unsigned quiet_cycles;

  function automatic int unsigned next_slot(int unsigned idx, int unsigned slots);
    return (idx + 1 >= slots) ? 0 : idx + 1;
  endfunction

  // Work out the results of one accepted operation and queue them.
  function automatic void predict_queue_op(logic [tcq_pkg::KIND_W-1:0] kind,
                                           logic [tcq_pkg::TAG_W-1:0] tag);
    int unsigned   slots;
    int unsigned   idx;
    queue_result_t res;
    slots = (model_capacity == 0) ? 1 :
            (model_capacity > DEPTH) ? DEPTH : int'(model_capacity);
    res = '0;
    res.last = 1'b1;
    case (kind)
      tcq_pkg::KIND_ENQ: begin
        if (model_count >= slots) begin
          res.status = tcq_pkg::ST_FULL;
        end else begin
          if (model_tail >= slots) model_tail = 0;
          model_tags[model_tail]    = tag;
          model_tickets[model_tail] = model_next_ticket;
          res.status = tcq_pkg::ST_OK;
          res.ticket = model_next_ticket;
          model_tail = next_slot(model_tail, slots);
          model_count++;
          model_next_ticket = model_next_ticket + 1'b1;
        end
        pending_results.push_back(res);
      end
      tcq_pkg::KIND_DEQ: begin
        if (model_count == 0 || model_head >= slots) begin
          res.status = tcq_pkg::ST_EMPTY;
        end else begin
          res.status    = tcq_pkg::ST_OK;
          res.entry_tag = model_tags[model_head];
          res.ticket    = model_tickets[model_head];
          model_head = next_slot(model_head, slots);
          model_count--;
        end
        pending_results.push_back(res);
      end
      tcq_pkg::KIND_LIST: begin
        if (model_count == 0 || model_head >= slots) begin
          res.status = tcq_pkg::ST_EMPTY;
          pending_results.push_back(res);
        end else begin
          idx = model_head;
          for (int unsigned i = 0; i < model_count && i < DEPTH; i++) begin
            res.status    = tcq_pkg::ST_OK;
            res.position  = tcq_pkg::POS_W'(i + 1);
            res.entry_tag = model_tags[idx];
            res.ticket    = model_tickets[idx];
            res.last      = (i + 1 == model_count);
            pending_results.push_back(res);
            idx = next_slot(idx, slots);
          end
        end
      end
      default: begin
        // unused code: dropped by the block
      end
    endcase
  endfunction

  task automatic note_mismatch(string what, queue_result_t exp, queue_result_t act);
    errors++;
    if (errors <= MAX_REPORTS)
      $display({"[%0t] %s: exp st=%0d pos=%0d tag=%h tkt=%h last=%b",
                " | got st=%0d pos=%0d tag=%h tkt=%h last=%b"},
               $realtime, what, exp.status, exp.position, exp.entry_tag, exp.ticket,
               exp.last, act.status, act.position, act.entry_tag, act.ticket, act.last);
  endtask

  // Compare each result transfer with the oldest prediction; randomize ready.
  always @(posedge clk) begin : result_check
    queue_result_t got;
    queue_result_t exp;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.status, out_if.position, out_if.entry_tag, out_if.ticket,
                out_if.last};
        results_checked++;
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          exp = pending_results.pop_front();
          if (got !== exp) note_mismatch("result mismatch", exp, got);
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("ticketed_circular_queue_top regression: fail");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [tcq_pkg::KIND_W-1:0] kind,
                         input logic [tcq_pkg::TAG_W-1:0] tag);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.client_tag <= tag;
    do @(posedge clk); while (!in_if.ready);
    predict_queue_op(kind, tag);
    ops_sent++;
  endtask

  // Hold the sender until every result is back, then let the block settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_capacity();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CAP_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[tcq_pkg::CAP_W-1:0] !== model_capacity) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("[%0t] capacity readback: exp %0d got %0d",
                 $realtime, model_capacity, cfg_prdata[tcq_pkg::CAP_W-1:0]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write the capacity, empty the model queue, and read the register back.
  task automatic write_capacity(input logic [tcq_pkg::CAP_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CAP_ADDR;
    cfg_pwdata  <= tcq_pkg::CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    model_capacity = value;
    model_head     = 0;
    model_tail     = 0;
    model_count    = 0;
    cap_writes++;
    @(posedge clk);
    read_capacity();
  endtask

  task automatic test_reset_state();
    read_capacity();
    send_op(tcq_pkg::KIND_DEQ, '1);
    send_op(tcq_pkg::KIND_LIST, '0);
  endtask

  task automatic test_fill_and_list();
    wait_idle();
    write_capacity(5'd2);
    send_op(tcq_pkg::KIND_ENQ, '0);
    send_op(tcq_pkg::KIND_ENQ, '1);
    send_op(tcq_pkg::KIND_ENQ, 64'h0123_4567_89ab_cdef);
    send_op(tcq_pkg::KIND_LIST, '0);
    send_op(KIND_UNUSED, 64'hdead_beef_dead_beef);
    send_op(tcq_pkg::KIND_DEQ, '0);
    send_op(tcq_pkg::KIND_DEQ, '1);
    send_op(tcq_pkg::KIND_DEQ, '0);
    send_op(tcq_pkg::KIND_LIST, '1);
    send_op(tcq_pkg::KIND_ENQ, 64'haaaa_aaaa_aaaa_aaaa);
    send_op(tcq_pkg::KIND_ENQ, 64'h5555_5555_5555_5555);
    send_op(tcq_pkg::KIND_LIST, '0);
    send_op(tcq_pkg::KIND_DEQ, '0);
  endtask

  task automatic test_capacity_clamp();
    wait_idle();
    // zero acts as a single slot
    write_capacity(5'd0);
    send_op(tcq_pkg::KIND_ENQ, 64'h8000_0000_0000_0001);
    send_op(tcq_pkg::KIND_ENQ, 64'h7fff_ffff_ffff_fffe);
    send_op(tcq_pkg::KIND_LIST, '0);
    // a capacity write drops queued entries
    wait_idle();
    write_capacity(5'd31);
    send_op(tcq_pkg::KIND_DEQ, '0);
    send_op(tcq_pkg::KIND_ENQ, 64'hfeed_f00d_cafe_0042);
    send_op(tcq_pkg::KIND_DEQ, '0);
  endtask

  task automatic run_random_phase(input int unsigned idle, input int unsigned stall,
                                  input logic [tcq_pkg::CAP_W-1:0] cap,
                                  input int unsigned n_ops, input bit pause_mid);
    int unsigned                done_ops;
    int unsigned                roll;
    bit                         filling;
    bit                         paused;
    logic [tcq_pkg::KIND_W-1:0] kind;
    logic [tcq_pkg::TAG_W-1:0]  tag;
    wait_idle();
    idle_pct  = idle;
    stall_pct = stall;
    write_capacity(cap);
    done_ops = 0;
    filling  = 1'b1;
    paused   = 1'b0;
    while (done_ops < n_ops) begin
      // alternate between filling and draining stretches
      if ($urandom_range(9) == 0) filling = !filling;
      roll = $urandom_range(99);
      if (roll < 5)
        kind = KIND_UNUSED;
      else if (roll < 25)
        kind = tcq_pkg::KIND_LIST;
      else if (roll < (filling ? 80 : 45))
        kind = tcq_pkg::KIND_ENQ;
      else
        kind = tcq_pkg::KIND_DEQ;
      tag = {$urandom, $urandom};
      case ($urandom_range(15))
        0: tag = '0;
        1: tag = '1;
        default: ;
      endcase
      send_op(kind, tag);
      if (kind != KIND_UNUSED) done_ops++;
      if (pause_mid && !paused && done_ops >= n_ops / 2) begin
        paused = 1'b1;
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0,  0,  5'd16, 40, 1'b0);
    run_random_phase(50, 0,  5'd1,  25, 1'b0);
    run_random_phase(0,  50, 5'd31, 40, 1'b1);
    run_random_phase(16, 16, 5'd0,  25, 1'b0);
    run_random_phase(0,  0,  5'd5,  40, 1'b0);
    run_random_phase(16, 16, 5'd17, 20, 1'b0);
    run_random_phase(0,  50, tcq_pkg::CAP_W'($urandom_range(2, 15)), 25, 1'b0);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.kind       = tcq_pkg::KIND_ENQ;
    in_if.client_tag = '0;
    out_if.ready     = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    foreach (model_tags[i]) begin
      model_tags[i]    = '0;
      model_tickets[i] = '0;
    end
    model_head        = 0;
    model_tail        = 0;
    model_count       = 0;
    model_next_ticket = tcq_pkg::TICKET_RESET;
    model_capacity    = tcq_pkg::CAP_RESET;
    idle_pct          = 0;
    stall_pct         = 0;
    ops_sent          = 0;
    results_checked   = 0;
    cap_writes        = 0;
    errors            = 0;
    quiet_cycles      = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_fill_and_list();
    test_capacity_clamp();
    test_random_traffic();

    wait_idle();
    errors += pending_results.size();
    $display("Sent %0d queue operations and checked %0d results across %0d capacity settings,",
             ops_sent, results_checked, cap_writes);
    $display("with sender gaps and receiver stalls mixed in, including clamped capacities.");
    if (errors == 0) begin
      $display("ticketed_circular_queue_top regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("ticketed_circular_queue_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/tcq_pkg.sv
hdl/tcq_ifs.sv
hdl/tcq_ram.sv
hdl/tcq_ctrl.sv
hdl/tcq_dp.sv
hdl/ticketed_circular_queue_top.sv
tb/tb_ticketed_circular_queue_top.sv
